FILE: rtl/rfca_pkg.sv
// Shared types and constants of the rigid frame chain accumulator.
// Depends on nothing; every other file of the block imports it.
package rfca_pkg;

	localparam int ROT_W         = 16;
	localparam int TRANS_W       = 32;
	localparam int ROW_W         = 3 * ROT_W;
	localparam int ROT_FRAC_BITS = 14;

	typedef logic signed [ROT_W-1:0]   rot_t;
	typedef logic signed [TRANS_W-1:0] trans_t;

	localparam rot_t   ROT_MAX   = rot_t'({1'b0, {(ROT_W-1){1'b1}}});
	localparam rot_t   ROT_MIN   = rot_t'({1'b1, {(ROT_W-1){1'b0}}});
	localparam trans_t TRANS_MAX = trans_t'({1'b0, {(TRANS_W-1){1'b1}}});
	localparam trans_t TRANS_MIN = trans_t'({1'b1, {(TRANS_W-1){1'b0}}});

	// Unit diagonal entry, clipped when the fraction leaves no room for it.
	localparam rot_t ROT_ONE = (ROT_FRAC_BITS >= ROT_W - 1) ? ROT_MAX :
		rot_t'(64'd1 << ROT_FRAC_BITS);

	// Rotation row-major, index row*3+column.
	typedef struct packed {
		rot_t   [8:0] rot;
		trans_t [2:0] trans;
	} frame_t;

	typedef struct packed {
		logic         first;
		rot_t   [8:0] rot;
		trans_t [2:0] trans;
	} link_t;

	function automatic frame_t identity_frame();
		frame_t f;
		for (int n = 0; n < 9; n++) begin
			f.rot[n] = (n % 4 == 0) ? ROT_ONE : '0;
		end
		f.trans = '0;
		return f;
	endfunction

endpackage

FILE: rtl/rfca_if.sv
// Valid/ready channels of the rigid frame chain accumulator: link words in,
// frame words out. Depends on rfca_pkg for field widths.
interface rfca_link_if import rfca_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  first_link;
	logic [ROW_W-1:0]      rot_row0;
	logic [ROW_W-1:0]      rot_row1;
	logic [ROW_W-1:0]      rot_row2;
	logic signed [TRANS_W-1:0] link_tx;
	logic signed [TRANS_W-1:0] link_ty;
	logic signed [TRANS_W-1:0] link_tz;

	modport source (
		output valid, first_link, rot_row0, rot_row1, rot_row2, link_tx, link_ty, link_tz,
		input  ready
	);
	modport sink (
		input  valid, first_link, rot_row0, rot_row1, rot_row2, link_tx, link_ty, link_tz,
		output ready
	);
endinterface

interface rfca_frame_if import rfca_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [ROT_W-1:0]   frame_r00;
	logic signed [ROT_W-1:0]   frame_r01;
	logic signed [ROT_W-1:0]   frame_r02;
	logic signed [ROT_W-1:0]   frame_r10;
	logic signed [ROT_W-1:0]   frame_r11;
	logic signed [ROT_W-1:0]   frame_r12;
	logic signed [ROT_W-1:0]   frame_r20;
	logic signed [ROT_W-1:0]   frame_r21;
	logic signed [ROT_W-1:0]   frame_r22;
	logic signed [TRANS_W-1:0] frame_tx;
	logic signed [TRANS_W-1:0] frame_ty;
	logic signed [TRANS_W-1:0] frame_tz;

	modport source (
		output valid, frame_r00, frame_r01, frame_r02, frame_r10, frame_r11, frame_r12,
			frame_r20, frame_r21, frame_r22, frame_tx, frame_ty, frame_tz,
		input  ready
	);
	modport sink (
		input  valid, frame_r00, frame_r01, frame_r02, frame_r10, frame_r11, frame_r12,
			frame_r20, frame_r21, frame_r22, frame_tx, frame_ty, frame_tz,
		output ready
	);
endinterface

FILE: rtl/rfca_compose.sv
// Composes the running frame with one link: R' = R * Rl, T' = R * tl + T,
// rounded half up and saturated. Combinational; depends on rfca_pkg.
module rfca_compose import rfca_pkg::*; (
	input  frame_t cur,
	input  link_t  lnk,
	output frame_t nxt
);

	localparam int RP_W = 2 * ROT_W;
	localparam int RS_W = RP_W + 3;
	localparam int TP_W = ROT_W + TRANS_W;
	localparam int TS_W = TP_W + 3;

	localparam logic signed [RS_W-1:0] HALF_R  = RS_W'(64'd1 << (ROT_FRAC_BITS - 1));
	localparam logic signed [TS_W-1:0] HALF_T  = TS_W'(64'd1 << (ROT_FRAC_BITS - 1));
	localparam logic signed [RS_W-1:0] RMAX    = RS_W'(ROT_MAX);
	localparam logic signed [RS_W-1:0] RMIN    = RS_W'(ROT_MIN);
	localparam logic signed [TS_W-1:0] TMAX    = TS_W'(TRANS_MAX);
	localparam logic signed [TS_W-1:0] TMIN    = TS_W'(TRANS_MIN);

	rot_t   nrot [9];
	trans_t ntr  [3];

	for (genvar gi = 0; gi < 3; gi++) begin : g_row
		// Rotation entries of this row
		for (genvar gk = 0; gk < 3; gk++) begin : g_col
			logic signed [RP_W-1:0] prod [3];
			logic signed [RS_W-1:0] sum;
			logic signed [RS_W-1:0] shr;

			for (genvar gj = 0; gj < 3; gj++) begin : g_mul
				assign prod[gj] = $signed(cur.rot[gi*3+gj]) * $signed(lnk.rot[gj*3+gk]);
			end

			assign sum = RS_W'(prod[0]) + RS_W'(prod[1]) + RS_W'(prod[2]) + HALF_R;
			assign shr = sum >>> ROT_FRAC_BITS;
			assign nrot[gi*3+gk] = (shr > RMAX) ? ROT_MAX :
				(shr < RMIN) ? ROT_MIN : rot_t'(shr);
		end

		// Translation component of this row
		logic signed [TP_W-1:0] tprod [3];
		logic signed [TS_W-1:0] tsum;
		logic signed [TS_W-1:0] tshr;
		logic signed [TS_W-1:0] tnew;

		for (genvar gj = 0; gj < 3; gj++) begin : g_tmul
			assign tprod[gj] = $signed(cur.rot[gi*3+gj]) * $signed(lnk.trans[gj]);
		end

		assign tsum = TS_W'(tprod[0]) + TS_W'(tprod[1]) + TS_W'(tprod[2]) + HALF_T;
		assign tshr = tsum >>> ROT_FRAC_BITS;
		assign tnew = tshr + TS_W'($signed(cur.trans[gi]));
		assign ntr[gi] = (tnew > TMAX) ? TRANS_MAX :
			(tnew < TMIN) ? TRANS_MIN : trans_t'(tnew);
	end

	always_comb begin
		for (int n = 0; n < 9; n++) begin
			nxt.rot[n] = nrot[n];
		end
		for (int n = 0; n < 3; n++) begin
			nxt.trans[n] = ntr[n];
		end
	end

endmodule

FILE: rtl/rigid_frame_chain_accumulator.sv
// Top level of the rigid frame chain accumulator.
// Depends on rfca_pkg, rfca_if (link and frame channels) and rfca_compose.
//
// Takes one chain link a word and returns, for each link, the running frame
// as it stood before that link (identity for a first_link word), then
// folds the link into the frame. One link is taken every cycle; its link is
// held in the link register, and its result then in the result register,
// before the result is presented. The rate is set by the combinational
// compose unit (36 multipliers) that feeds the frame register straight back.
// Back-pressure on the frame channel stalls the input once the link register
// and the result register are both full.
module rigid_frame_chain_accumulator import rfca_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	rfca_link_if.sink    link,
	rfca_frame_if.source frame
);

	link_t  link_in;
	link_t  link_s1;
	logic   valid_s1;
	frame_t state_q;
	frame_t out_q;
	logic   out_valid_q;
	frame_t frame_cur;
	frame_t frame_nxt;
	logic   advance;
	logic   take;

	// Unpack the channel word
	always_comb begin
		link_in.first = link.first_link;
		for (int k = 0; k < 3; k++) begin
			link_in.rot[k]     = rot_t'(link.rot_row0[k*ROT_W +: ROT_W]);
			link_in.rot[3 + k] = rot_t'(link.rot_row1[k*ROT_W +: ROT_W]);
			link_in.rot[6 + k] = rot_t'(link.rot_row2[k*ROT_W +: ROT_W]);
		end
		link_in.trans[0] = link.link_tx;
		link_in.trans[1] = link.link_ty;
		link_in.trans[2] = link.link_tz;
	end

	assign advance    = valid_s1 && (!out_valid_q || frame.ready);
	assign link.ready = !valid_s1 || advance;
	assign take       = link.valid && link.ready;

	assign frame_cur = link_s1.first ? identity_frame() : state_q;

	rfca_compose u_compose (
		.cur (frame_cur),
		.lnk (link_s1),
		.nxt (frame_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= identity_frame();
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				state_q     <= frame_nxt;
			end else if (frame.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: hold unless a word moves
	always_ff @(posedge clk) begin
		if (take) begin
			link_s1 <= link_in;
		end
		if (advance) begin
			out_q <= frame_cur;
		end
	end

	assign frame.valid     = out_valid_q;
	assign frame.frame_r00 = out_q.rot[0];
	assign frame.frame_r01 = out_q.rot[1];
	assign frame.frame_r02 = out_q.rot[2];
	assign frame.frame_r10 = out_q.rot[3];
	assign frame.frame_r11 = out_q.rot[4];
	assign frame.frame_r12 = out_q.rot[5];
	assign frame.frame_r20 = out_q.rot[6];
	assign frame.frame_r21 = out_q.rot[7];
	assign frame.frame_r22 = out_q.rot[8];
	assign frame.frame_tx  = out_q.trans[0];
	assign frame.frame_ty  = out_q.trans[1];
	assign frame.frame_tz  = out_q.trans[2];

endmodule

FILE: test/tb_rigid_frame_chain_accumulator.sv
// Testbench of the rigid frame chain accumulator: drives link words, predicts
// each running frame with a fixed-point model of its own and checks frame words.
// Depends on rfca_pkg, rfca_if and the rigid_frame_chain_accumulator top level.
module tb_rigid_frame_chain_accumulator;
	import rfca_pkg::*;

	class frame_scoreboard;
		rot_t   cur_rot[9];
		trans_t cur_trans[3];
		frame_t expected_frames[$];
		int     errors;
		string  rot_names[9] = '{"frame_r00", "frame_r01", "frame_r02",
			"frame_r10", "frame_r11", "frame_r12", "frame_r20", "frame_r21", "frame_r22"};
		string  trans_names[3] = '{"frame_tx", "frame_ty", "frame_tz"};

		function new();
			errors = 0;
			restart();
		endfunction

		static function rot_t clip_rot(longint v);
			if (v > longint'(ROT_MAX)) return ROT_MAX;
			if (v < longint'(ROT_MIN)) return ROT_MIN;
			return rot_t'(v);
		endfunction

		static function trans_t clip_trans(longint v);
			if (v > longint'(TRANS_MAX)) return TRANS_MAX;
			if (v < longint'(TRANS_MIN)) return TRANS_MIN;
			return trans_t'(v);
		endfunction

		// Round half up: add half an lsb, then floor-shift.
		static function longint round_q(longint v);
			return (v + (longint'(1) << (ROT_FRAC_BITS - 1))) >>> ROT_FRAC_BITS;
		endfunction

		function void restart();
			rot_t unit;
			unit = clip_rot(longint'(1) << ROT_FRAC_BITS);
			for (int n = 0; n < 9; n++) cur_rot[n] = (n % 4 == 0) ? unit : rot_t'(0);
			for (int n = 0; n < 3; n++) cur_trans[n] = '0;
		endfunction

		function void note_link(link_t l);
			frame_t f;
			rot_t   nr[9];
			trans_t nt[3];
			longint acc;
			if (l.first) restart();
			for (int n = 0; n < 9; n++) f.rot[n] = cur_rot[n];
			for (int n = 0; n < 3; n++) f.trans[n] = cur_trans[n];
			expected_frames.insert(expected_frames.size(), f);
			for (int i = 0; i < 3; i++) begin
				acc = 0;
				for (int j = 0; j < 3; j++)
					acc += longint'(cur_rot[i*3+j]) * longint'($signed(l.trans[j]));
				nt[i] = clip_trans(round_q(acc) + longint'(cur_trans[i]));
				for (int k = 0; k < 3; k++) begin
					acc = 0;
					for (int j = 0; j < 3; j++)
						acc += longint'(cur_rot[i*3+j]) * longint'($signed(l.rot[j*3+k]));
					nr[i*3+k] = clip_rot(round_q(acc));
				end
			end
			cur_rot = nr;
			cur_trans = nt;
		endfunction

		function void check_frame(frame_t got);
			frame_t want;
			if (expected_frames.size() == 0) begin
				errors++;
				$error("frame word with no link waiting");
				return;
			end
			want = expected_frames.pop_front();
			for (int n = 0; n < 9; n++)
				if (got.rot[n] !== want.rot[n]) begin
					errors++;
					$error("%s: expected %0d, got %0d", rot_names[n],
						$signed(want.rot[n]), $signed(got.rot[n]));
				end
			for (int n = 0; n < 3; n++)
				if (got.trans[n] !== want.trans[n]) begin
					errors++;
					$error("%s: expected %0d, got %0d", trans_names[n],
						$signed(want.trans[n]), $signed(got.trans[n]));
				end
		endfunction

		function int pending();
			return expected_frames.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   gap_pct;
	int   stall_pct;

	frame_scoreboard frame_board;

	rfca_link_if  link_ch();
	rfca_frame_if frame_ch();

	rigid_frame_chain_accumulator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.link   (link_ch),
		.frame  (frame_ch)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("tb_rigid_frame_chain_accumulator: done, errors");
		$finish;
	end

	function automatic link_t uniform_link(bit first, rot_t diag, rot_t off,
			trans_t tx, trans_t ty, trans_t tz);
		link_t l;
		l.first = first;
		for (int n = 0; n < 9; n++) l.rot[n] = (n % 4 == 0) ? diag : off;
		l.trans[0] = tx;
		l.trans[1] = ty;
		l.trans[2] = tz;
		return l;
	endfunction

	function automatic rot_t random_entry(int mode);
		case (mode)
			0: return rot_t'($urandom);
			1: return rot_t'(int'($urandom_range(0, 32768)) - 16384);
			2: begin
				case ($urandom_range(0, 4))
					0: return ROT_MIN;
					1: return ROT_MAX;
					2: return rot_t'(0);
					3: return ROT_ONE;
					default: return -ROT_ONE;
				endcase
			end
			default: return random_entry($urandom_range(0, 2));
		endcase
	endfunction

	function automatic trans_t random_offset(int mode);
		case (mode)
			0: return trans_t'($urandom);
			1: return trans_t'(int'($urandom_range(0, 2097152)) - 1048576);
			default: begin
				case ($urandom_range(0, 4))
					0: return TRANS_MIN;
					1: return TRANS_MAX;
					2: return trans_t'(0);
					3: return trans_t'(-1);
					default: return trans_t'(1);
				endcase
			end
		endcase
	endfunction

	function automatic link_t random_link(bit first, int rot_mode, int trans_mode);
		link_t l;
		l.first = first;
		for (int n = 0; n < 9; n++) l.rot[n] = random_entry(rot_mode);
		for (int n = 0; n < 3; n++) l.trans[n] = random_offset(trans_mode);
		return l;
	endfunction

	// Present one link word and hold it until the block takes it.
	task automatic send_link(link_t l);
		if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
			link_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		link_ch.valid      <= 1'b1;
		link_ch.first_link <= l.first;
		link_ch.rot_row0   <= {l.rot[2], l.rot[1], l.rot[0]};
		link_ch.rot_row1   <= {l.rot[5], l.rot[4], l.rot[3]};
		link_ch.rot_row2   <= {l.rot[8], l.rot[7], l.rot[6]};
		link_ch.link_tx    <= l.trans[0];
		link_ch.link_ty    <= l.trans[1];
		link_ch.link_tz    <= l.trans[2];
		do @(posedge clk); while (!link_ch.ready);
	endtask

	// Back-pressure on the frame channel.
	initial begin
		frame_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
				frame_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			frame_ch.ready <= 1'b1;
		end
	end

	// Note links and check frames in one process so that order within an edge holds.
	always @(posedge clk) begin
		link_t  seen;
		frame_t got;
		if (arst_n) begin
			if (link_ch.valid && link_ch.ready) begin
				seen.first = link_ch.first_link;
				for (int c = 0; c < 3; c++) begin
					seen.rot[c]   = link_ch.rot_row0[ROT_W*c +: ROT_W];
					seen.rot[3+c] = link_ch.rot_row1[ROT_W*c +: ROT_W];
					seen.rot[6+c] = link_ch.rot_row2[ROT_W*c +: ROT_W];
				end
				seen.trans[0] = link_ch.link_tx;
				seen.trans[1] = link_ch.link_ty;
				seen.trans[2] = link_ch.link_tz;
				frame_board.note_link(seen);
			end
			if (frame_ch.valid && frame_ch.ready) begin
				got.rot[0]   = frame_ch.frame_r00;
				got.rot[1]   = frame_ch.frame_r01;
				got.rot[2]   = frame_ch.frame_r02;
				got.rot[3]   = frame_ch.frame_r10;
				got.rot[4]   = frame_ch.frame_r11;
				got.rot[5]   = frame_ch.frame_r12;
				got.rot[6]   = frame_ch.frame_r20;
				got.rot[7]   = frame_ch.frame_r21;
				got.rot[8]   = frame_ch.frame_r22;
				got.trans[0] = frame_ch.frame_tx;
				got.trans[1] = frame_ch.frame_ty;
				got.trans[2] = frame_ch.frame_tz;
				frame_board.check_frame(got);
			end
		end
	end

	initial begin
		link_t l;
		int    chain_len;
		int    rot_mode;
		int    trans_mode;
		int    sent;
		frame_board = new();
		gap_pct   = 25;
		stall_pct = 25;
		arst_n             <= 1'b0;
		link_ch.valid      <= 1'b0;
		link_ch.first_link <= 1'b0;
		link_ch.rot_row0   <= '0;
		link_ch.rot_row1   <= '0;
		link_ch.rot_row2   <= '0;
		link_ch.link_tx    <= '0;
		link_ch.link_ty    <= '0;
		link_ch.link_tz    <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: restart, saturation both ways, half-up rounding, zero rotation.
		send_link(uniform_link(1'b1, ROT_ONE, rot_t'(0), 0, 0, 0));
		send_link(uniform_link(1'b0, ROT_ONE, rot_t'(0), 32'sh0001_0000, 32'sh0002_0000,
			-32'sh0003_0000));
		send_link(uniform_link(1'b0, ROT_MAX, ROT_MAX, TRANS_MAX, TRANS_MAX, TRANS_MAX));
		send_link(uniform_link(1'b0, ROT_MIN, ROT_MIN, TRANS_MIN, TRANS_MIN, TRANS_MIN));
		send_link(uniform_link(1'b0, ROT_MAX, ROT_MIN, TRANS_MAX, TRANS_MIN, 0));
		send_link(uniform_link(1'b1, ROT_MIN, rot_t'(0), TRANS_MIN, TRANS_MAX, -1));
		send_link(uniform_link(1'b0, ROT_ONE, rot_t'(0), 1, -1, 0));
		send_link(uniform_link(1'b1, 16'sd8192, rot_t'(0), 0, 0, 0));
		send_link(uniform_link(1'b0, ROT_ONE, rot_t'(0), 1, -1, 3));
		send_link(uniform_link(1'b0, 16'sd1, -16'sd1, 0, 0, 0));
		send_link(uniform_link(1'b0, ROT_ONE, ROT_ONE, -1, -1, -1));
		send_link(uniform_link(1'b1, rot_t'(0), rot_t'(0), TRANS_MAX, TRANS_MIN, TRANS_MAX));
		send_link(uniform_link(1'b0, ROT_MAX, rot_t'(0), 5, 5, 5));
		send_link(uniform_link(1'b1, ROT_MAX, ROT_MAX, TRANS_MAX, TRANS_MAX, TRANS_MIN));
		send_link(uniform_link(1'b1, -ROT_ONE, ROT_ONE, TRANS_MIN, 1, TRANS_MAX));
		send_link(uniform_link(1'b0, ROT_MIN, ROT_MAX, TRANS_MAX, TRANS_MAX, TRANS_MAX));
		send_link(uniform_link(1'b0, -16'sd1, 16'sd1, -2, 2, 0));

		// Random chains, most opened by a first link; drop idling near the end.
		sent = 0;
		while (sent < 1150) begin
			chain_len  = $urandom_range(1, 16);
			rot_mode   = $urandom_range(0, 3);
			trans_mode = $urandom_range(0, 2);
			if (sent > 1000) begin
				gap_pct   = 0;
				stall_pct = 0;
			end else begin
				gap_pct   = 10 * $urandom_range(0, 3);
				stall_pct = 10 * $urandom_range(0, 3);
			end
			for (int n = 0; n < chain_len; n++) begin
				l = random_link((n == 0) ? ($urandom_range(0, 9) != 0) :
					($urandom_range(0, 29) == 0), rot_mode, trans_mode);
				send_link(l);
				sent++;
			end
		end
		link_ch.valid <= 1'b0;

		while (frame_board.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (frame_board.errors == 0)
			$display("tb_rigid_frame_chain_accumulator: done, clean");
		else
			$display("tb_rigid_frame_chain_accumulator: done, errors");
		$finish;
	end

endmodule

FILE: sim.f
rtl/rfca_pkg.sv
rtl/rfca_if.sv
rtl/rfca_compose.sv
rtl/rigid_frame_chain_accumulator.sv
test/tb_rigid_frame_chain_accumulator.sv
